FILE: design/tcw_pkg.sv
package tcw_pkg;

    parameter int COLUMNS_DEF       = 40;
    parameter int ROWS_DEF          = 28;
    parameter int HISTORY_LINES_DEF = 1024;
    parameter int TAB_SIZE_DEF      = 4;

    parameter int AREA_HEIGHT = 206;
    localparam logic [7:0] AREA_HEIGHT_B = 8'd206;
    localparam logic [7:0] AREA_TOP_B    = 8'd24;

    localparam logic [2:0] OP_CHAR      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_END       = 3'd2;
    localparam logic [2:0] OP_PAGE_UP   = 3'd3;
    localparam logic [2:0] OP_PAGE_DOWN = 3'd4;
    localparam logic [2:0] OP_LINE_UP   = 3'd5;
    localparam logic [2:0] OP_LINE_DOWN = 3'd6;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic        write_valid;
        logic [9:0]  write_line;
        logic [5:0]  write_col;
        logic [7:0]  write_char;
        logic [4:0]  cursor_row;
        logic [5:0]  cursor_col;
        logic [9:0]  view_top;
        logic [10:0] line_count;
        logic [7:0]  thumb_top;
        logic [7:0]  thumb_bottom;
        logic        last;
    } out_item_t;

endpackage

FILE: design/tcw_div.sv
module tcw_div #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den_in,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                num_reg  <= num_in;
                den_reg  <= den_in;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], ge};
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

FILE: design/tcw_thumb.sv
module tcw_thumb #(
    parameter int ROWS          = tcw_pkg::ROWS_DEF,
    parameter int HISTORY_LINES = tcw_pkg::HISTORY_LINES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [$clog2(HISTORY_LINES+1)-1:0]     end_val,
    input  logic [$clog2(HISTORY_LINES)-1:0]       view,
    output logic                                   done,
    output logic [7:0]                             thumb_top,
    output logic [7:0]                             thumb_bottom
);
    import tcw_pkg::*;

    localparam int CNT_W  = $clog2(HISTORY_LINES + 1);
    localparam int LINE_W = $clog2(HISTORY_LINES);
    localparam int NUM_W  = $clog2(AREA_HEIGHT * HISTORY_LINES);
    localparam logic [NUM_W-1:0] H_NUM  = NUM_W'(AREA_HEIGHT * (ROWS - 1));
    localparam logic [CNT_W-1:0] PAGE_C = CNT_W'(ROWS - 1);

    typedef enum logic [2:0] {
        T_IDLE,
        T_DIV_H,
        T_MUL,
        T_START_T,
        T_DIV_T
    } tstate_t;

    tstate_t            state_reg;
    logic [CNT_W-1:0]   end_reg;
    logic [LINE_W-1:0]  view_reg;
    logic [7:0]         h_reg;
    logic [NUM_W-1:0]   prod_reg;
    logic               div_start_reg;
    logic [NUM_W-1:0]   div_num_reg;
    logic [CNT_W-1:0]   div_den_reg;
    logic               done_reg;
    logic [7:0]         top_reg;
    logic [7:0]         bottom_reg;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic [7:0]         h_next;
    logic [7:0]         h_gap;
    logic [LINE_W+7:0]  prod_full;
    logic [7:0]         t_val;

    tcw_div #(
        .NUM_W(NUM_W),
        .DEN_W(CNT_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start_reg),
        .num_in (div_num_reg),
        .den_in (div_den_reg),
        .done   (div_done),
        .quot   (div_quot)
    );

    always_comb begin
        if (div_quot == '0) begin
            h_next = 8'd1;
        end else if (div_quot > NUM_W'(AREA_HEIGHT)) begin
            h_next = AREA_HEIGHT_B;
        end else begin
            h_next = div_quot[7:0];
        end
    end

    assign h_gap     = AREA_HEIGHT_B - h_reg;
    assign prod_full = {{LINE_W{1'b0}}, h_gap} * {8'd0, view_reg};
    assign t_val     = div_quot[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            div_start_reg <= 1'b0;
            done_reg      <= 1'b0;
            top_reg       <= '0;
            bottom_reg    <= '0;
        end else begin
            div_start_reg <= 1'b0;
            done_reg      <= 1'b0;
            case (state_reg)
                T_IDLE: begin
                    if (start) begin
                        end_reg       <= end_val;
                        view_reg      <= view;
                        div_num_reg   <= H_NUM;
                        div_den_reg   <= end_val + 1'b1;
                        div_start_reg <= 1'b1;
                        state_reg     <= T_DIV_H;
                    end
                end
                T_DIV_H: begin
                    if (div_done) begin
                        h_reg     <= h_next;
                        state_reg <= T_MUL;
                    end
                end
                T_MUL: begin
                    prod_reg  <= NUM_W'(prod_full);
                    state_reg <= T_START_T;
                end
                T_START_T: begin
                    div_num_reg   <= prod_reg;
                    div_den_reg   <= end_reg - PAGE_C;
                    div_start_reg <= 1'b1;
                    state_reg     <= T_DIV_T;
                end
                T_DIV_T: begin
                    if (div_done) begin
                        top_reg    <= AREA_TOP_B + t_val;
                        bottom_reg <= AREA_TOP_B + t_val + h_reg;
                        done_reg   <= 1'b1;
                        state_reg  <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign thumb_top    = top_reg;
    assign thumb_bottom = bottom_reg;

`ifndef NO_ASSERTIONS
    a_thumb_order: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (bottom_reg > top_reg))
        else $error("thumb bottom not below thumb top");
`endif

endmodule

FILE: design/tcw_store.sv
module tcw_store #(
    parameter int COLUMNS       = tcw_pkg::COLUMNS_DEF,
    parameter int HISTORY_LINES = tcw_pkg::HISTORY_LINES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [$clog2(HISTORY_LINES)-1:0]  wr_slot,
    input  logic [$clog2(COLUMNS)-1:0]        wr_col,
    input  logic [7:0]                        wr_data,
    output logic                              busy
);
    import tcw_pkg::*;

    localparam int DEPTH  = COLUMNS * HISTORY_LINES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LINE_W = $clog2(HISTORY_LINES);
    localparam int COL_W  = $clog2(COLUMNS);

    logic [7:0]        mem [DEPTH];
    logic              busy_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic              en1_reg;
    logic [LINE_W-1:0] slot1_reg;
    logic [COL_W-1:0]  col1_reg;
    logic [7:0]        data1_reg;
    logic              en2_reg;
    logic [ADDR_W-1:0] addr2_reg;
    logic [7:0]        data2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
            en1_reg  <= 1'b0;
            en2_reg  <= 1'b0;
        end else begin
            if (busy_reg) begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
            en1_reg   <= wr_en;
            slot1_reg <= wr_slot;
            col1_reg  <= wr_col;
            data1_reg <= wr_data;
            en2_reg   <= en1_reg;
            addr2_reg <= ADDR_W'(slot1_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col1_reg);
            data2_reg <= data1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_reg] <= CH_SPACE;
        end else if (en2_reg) begin
            mem[addr2_reg] <= data2_reg;
        end
    end

    assign busy = busy_reg;

endmodule

FILE: design/text_console_writer_with_scrollback.sv
// Text console writer with scrollback.
// Input channel s_valid/s_ready/s_item carries one item: a character (op 0)
// or a scroll command (ops 1 to 6). Result channel m_valid/m_ready/m_item
// returns one result per written cell, or one result when nothing is
// written; the final result of an item has last set.
// Each item is handled to completion before the next one is taken.
// Each thumb update runs the bit-serial divider, which is W bits wide,
// where W is clog2(206*HISTORY_LINES) (18 at the defaults), and which is
// shared by the thumb height and position.
// A character that scrolls the view costs one thumb update for the snap
// plus one per new line; a tab writes TAB_SIZE cells, one result each.
// A finished result sits in the output register; s_ready returns while it
// waits. When the receiver stalls, an item with several results holds in
// its emit step until the register frees up.
// Reset (aresetn low, synchronous) clears cursor, counts, view and thumb,
// then the text store is filled with spaces, one cell per cycle; s_ready
// stays low during that pass.
module text_console_writer_with_scrollback #(
    parameter int COLUMNS       = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS          = tcw_pkg::ROWS_DEF,
    parameter int HISTORY_LINES = tcw_pkg::HISTORY_LINES_DEF,
    parameter int TAB_SIZE      = tcw_pkg::TAB_SIZE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcw_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output tcw_pkg::out_item_t m_item
);
    import tcw_pkg::*;

    localparam int CNT_W  = $clog2(HISTORY_LINES + 1);
    localparam int LINE_W = $clog2(HISTORY_LINES);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int TAB_W  = $clog2(TAB_SIZE + 1);

    localparam logic [CNT_W-1:0]  PAGE_C    = CNT_W'(ROWS - 1);
    localparam logic [LINE_W-1:0] PAGE_L    = LINE_W'(ROWS - 1);
    localparam logic [LINE_W:0]   PAGE_X    = (LINE_W + 1)'(ROWS - 1);
    localparam logic [LINE_W:0]   HIST_X    = (LINE_W + 1)'(HISTORY_LINES);
    localparam logic [CNT_W-1:0]  LINES_MAX = CNT_W'(HISTORY_LINES);
    localparam logic [LINE_W-1:0] BASE_MAX  = LINE_W'(HISTORY_LINES - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COL_LIM   = (COL_W + 1)'(COLUMNS);
    localparam logic [TAB_W-1:0]  TAB_C     = TAB_W'(TAB_SIZE);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DISPATCH,
        ST_PUT,
        ST_NL,
        ST_NL2,
        ST_THUMB,
        ST_TWAIT,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    state_t            ret_reg;
    logic [CNT_W-1:0]  lines_reg;
    logic [LINE_W-1:0] base_reg;
    logic [LINE_W-1:0] view_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic              wrapped_reg;
    logic [2:0]        op_reg;
    logic [7:0]        ch_reg;
    logic [7:0]        put_char_reg;
    logic [TAB_W-1:0]  puts_left_reg;
    logic              wv_reg;
    logic [LINE_W-1:0] wline_reg;
    logic [COL_W-1:0]  wcol_reg;
    logic [7:0]        wchar_reg;
    logic              m_valid_reg;
    out_item_t         m_item_reg;

    logic [CNT_W-1:0]  scroll_end;
    logic              big;
    logic [LINE_W-1:0] top_pos;
    logic [LINE_W-1:0] line_sum;
    logic [LINE_W:0]   slot_sum;
    logic [LINE_W-1:0] slot;
    logic [COL_W:0]    col_inc;
    logic [LINE_W:0]   view_p1;
    logic [LINE_W:0]   view_pp;
    logic              slot_free;
    logic              store_busy;
    logic              thumb_done;
    logic [7:0]        thumb_top;
    logic [7:0]        thumb_bottom;

    assign scroll_end = (lines_reg == '0) ? '0 : lines_reg - 1'b1;
    assign big        = scroll_end > PAGE_C;
    assign top_pos    = LINE_W'(scroll_end - PAGE_C);
    assign line_sum   = view_reg + LINE_W'(row_reg);
    assign slot_sum   = {1'b0, base_reg} + {1'b0, line_sum};
    assign slot       = (slot_sum >= HIST_X) ? LINE_W'(slot_sum - HIST_X) : LINE_W'(slot_sum);
    assign col_inc    = {1'b0, col_reg} + 1'b1;
    assign view_p1    = {1'b0, view_reg} + 1'b1;
    assign view_pp    = {1'b0, view_reg} + PAGE_X;
    assign slot_free  = !m_valid_reg || m_ready;

    tcw_store #(
        .COLUMNS      (COLUMNS),
        .HISTORY_LINES(HISTORY_LINES)
    ) u_store (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (state_reg == ST_PUT),
        .wr_slot(slot),
        .wr_col (col_reg),
        .wr_data(put_char_reg),
        .busy   (store_busy)
    );

    tcw_thumb #(
        .ROWS         (ROWS),
        .HISTORY_LINES(HISTORY_LINES)
    ) u_thumb (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (state_reg == ST_THUMB),
        .end_val     (scroll_end),
        .view        (view_reg),
        .done        (thumb_done),
        .thumb_top   (thumb_top),
        .thumb_bottom(thumb_bottom)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            lines_reg     <= '0;
            base_reg      <= '0;
            view_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            wrapped_reg   <= 1'b0;
            puts_left_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (state_reg == ST_EMIT && slot_free) begin
                m_valid_reg             <= 1'b1;
                m_item_reg.write_valid  <= wv_reg;
                m_item_reg.write_line   <= 10'(wline_reg);
                m_item_reg.write_col    <= 6'(wcol_reg);
                m_item_reg.write_char   <= wchar_reg;
                m_item_reg.cursor_row   <= 5'(row_reg);
                m_item_reg.cursor_col   <= 6'(col_reg);
                m_item_reg.view_top     <= 10'(view_reg);
                m_item_reg.line_count   <= 11'(lines_reg);
                m_item_reg.thumb_top    <= thumb_top;
                m_item_reg.thumb_bottom <= thumb_bottom;
                m_item_reg.last         <= (puts_left_reg == '0);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg    <= s_item.op;
                        ch_reg    <= s_item.ch;
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    puts_left_reg <= '0;
                    wv_reg        <= 1'b0;
                    wline_reg     <= '0;
                    wcol_reg      <= '0;
                    wchar_reg     <= '0;
                    if (op_reg == OP_CHAR) begin
                        if (big) begin
                            view_reg  <= top_pos;
                            ret_reg   <= ST_DISPATCH;
                            state_reg <= ST_THUMB;
                        end else begin
                            state_reg <= ST_DISPATCH;
                        end
                    end else if (!big) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        ret_reg   <= ST_EMIT;
                        state_reg <= ST_THUMB;
                        case (op_reg)
                            OP_START: begin
                                view_reg <= '0;
                            end
                            OP_END: begin
                                view_reg <= top_pos;
                            end
                            OP_PAGE_UP: begin
                                view_reg <= (view_reg > PAGE_L) ? view_reg - PAGE_L : '0;
                            end
                            OP_PAGE_DOWN: begin
                                view_reg <= (view_pp > {1'b0, top_pos}) ? top_pos
                                                                        : LINE_W'(view_pp);
                            end
                            OP_LINE_UP: begin
                                view_reg <= (view_reg != '0) ? view_reg - 1'b1 : '0;
                            end
                            OP_LINE_DOWN: begin
                                view_reg <= (view_p1 > {1'b0, top_pos}) ? top_pos
                                                                        : LINE_W'(view_p1);
                            end
                            default: begin
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_DISPATCH: begin
                    case (ch_reg)
                        CH_NUL: begin
                            state_reg <= ST_EMIT;
                        end
                        CH_LF: begin
                            wrapped_reg <= 1'b0;
                            if (!wrapped_reg) begin
                                ret_reg   <= ST_EMIT;
                                state_reg <= ST_NL;
                            end else begin
                                state_reg <= ST_EMIT;
                            end
                        end
                        CH_CR: begin
                            col_reg   <= '0;
                            state_reg <= ST_EMIT;
                        end
                        CH_TAB: begin
                            puts_left_reg <= TAB_C;
                            put_char_reg  <= CH_SPACE;
                            state_reg     <= ST_PUT;
                        end
                        default: begin
                            wrapped_reg   <= 1'b0;
                            puts_left_reg <= TAB_W'(1);
                            put_char_reg  <= ch_reg;
                            state_reg     <= ST_PUT;
                        end
                    endcase
                end
                ST_PUT: begin
                    wv_reg        <= 1'b1;
                    wline_reg     <= line_sum;
                    wcol_reg      <= col_reg;
                    wchar_reg     <= put_char_reg;
                    puts_left_reg <= puts_left_reg - 1'b1;
                    if (col_inc >= COL_LIM) begin
                        col_reg     <= '0;
                        wrapped_reg <= 1'b1;
                        ret_reg     <= ST_EMIT;
                        state_reg   <= ST_NL;
                    end else begin
                        col_reg   <= COL_W'(col_inc);
                        state_reg <= ST_EMIT;
                    end
                end
                ST_NL: begin
                    if (lines_reg < LINES_MAX) begin
                        lines_reg <= lines_reg + 1'b1;
                    end else begin
                        base_reg <= (base_reg == BASE_MAX) ? '0 : base_reg + 1'b1;
                    end
                    if (row_reg < ROW_MAX) begin
                        row_reg <= row_reg + 1'b1;
                    end
                    col_reg   <= '0;
                    state_reg <= ST_NL2;
                end
                ST_NL2: begin
                    if (big) begin
                        view_reg  <= (view_p1 > {1'b0, top_pos}) ? top_pos : LINE_W'(view_p1);
                        state_reg <= ST_THUMB;
                    end else begin
                        state_reg <= ret_reg;
                    end
                end
                ST_THUMB: begin
                    state_reg <= ST_TWAIT;
                end
                ST_TWAIT: begin
                    if (thumb_done) begin
                        state_reg <= ret_reg;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        state_reg <= (puts_left_reg != '0) ? ST_PUT : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !store_busy;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef NO_ASSERTIONS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while another is in flight");

    a_view_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (view_reg == '0) || (big && (CNT_W'(view_reg) <= scroll_end - PAGE_C)))
        else $error("view beyond scroll range");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg <= ROW_MAX) && ({1'b0, col_reg} < COL_LIM))
        else $error("cursor outside window");

    a_lines_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (lines_reg <= LINES_MAX) && ((lines_reg == LINES_MAX) || (base_reg == '0)))
        else $error("ring base moved before history filled");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int unsigned COLS  = COLUMNS_DEF;
    localparam int unsigned PAGE  = ROWS_DEF - 1;
    localparam int unsigned HIST  = HISTORY_LINES_DEF;
    localparam int unsigned TABW  = TAB_SIZE_DEF;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int unsigned WATCHDOG_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES   = 200;
    localparam int unsigned RX_HOLD_CYCLES = 400;

    class console_tracker;
        int unsigned lines_used, cur_row, cur_col, view_pos, thumb_top_q, thumb_bot_q;
        bit wrapped;
        out_item_t step_q[$];
        out_item_t screen_updates[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            lines_used = 0;
            cur_row = 0;
            cur_col = 0;
            view_pos = 0;
            thumb_top_q = 0;
            thumb_bot_q = 0;
            wrapped = 1'b0;
            mismatches = 0;
            checked = 0;
        endfunction

        function int unsigned pending();
            return screen_updates.size();
        endfunction

        function int unsigned scroll_end();
            return (lines_used != 0) ? lines_used - 1 : 0;
        endfunction

        function void move_thumb();
            int unsigned span, h, t;
            span = scroll_end();
            if (span <= PAGE) return;
            h = (AREA_HEIGHT * PAGE) / (span + 1);
            if (h < 1) h = 1;
            if (h > AREA_HEIGHT) h = AREA_HEIGHT;
            t = ((AREA_HEIGHT - h) * view_pos) / (span - PAGE);
            thumb_top_q = 32'(AREA_TOP_B) + t;
            thumb_bot_q = 32'(AREA_TOP_B) + t + h;
        endfunction

        function void advance_line();
            int unsigned span;
            if (lines_used < HIST) lines_used++;
            span = scroll_end();
            if (span > PAGE) begin
                view_pos++;
                if (view_pos > span - PAGE) view_pos = span - PAGE;
                move_thumb();
            end
            if (cur_row < PAGE) cur_row++;
            cur_col = 0;
        endfunction

        function void push_result(bit wv, int unsigned line, int unsigned col, logic [7:0] c);
            out_item_t r;
            r.write_valid  = wv;
            r.write_line   = 10'(line);
            r.write_col    = 6'(col);
            r.write_char   = c;
            r.cursor_row   = 5'(cur_row);
            r.cursor_col   = 6'(cur_col);
            r.view_top     = 10'(view_pos);
            r.line_count   = 11'(lines_used);
            r.thumb_top    = 8'(thumb_top_q);
            r.thumb_bottom = 8'(thumb_bot_q);
            r.last         = 1'b0;
            step_q.push_back(r);
        endfunction

        function void put_cell(logic [7:0] c);
            int unsigned line, col;
            line = view_pos + cur_row;
            col = cur_col;
            cur_col++;
            if (cur_col >= COLS) begin
                cur_col = 0;
                wrapped = 1'b1;
                advance_line();
            end
            push_result(1'b1, line, col, c);
        endfunction

        function void take_item(in_item_t it);
            int unsigned span, top;
            out_item_t r;
            step_q.delete();
            span = scroll_end();
            if (it.op == OP_CHAR) begin
                if (span > PAGE) begin
                    view_pos = span - PAGE;
                    move_thumb();
                end
                case (it.ch)
                    CH_NUL: ;
                    CH_LF: begin
                        if (!wrapped) advance_line();
                        wrapped = 1'b0;
                    end
                    CH_CR: cur_col = 0;
                    CH_TAB: repeat (TABW) put_cell(CH_SPACE);
                    default: begin
                        wrapped = 1'b0;
                        put_cell(it.ch);
                    end
                endcase
            end else if (it.op <= OP_LINE_DOWN && span > PAGE) begin
                top = span - PAGE;
                case (it.op)
                    OP_START: view_pos = 0;
                    OP_END: view_pos = top;
                    OP_PAGE_UP: view_pos = (view_pos > PAGE) ? view_pos - PAGE : 0;
                    OP_PAGE_DOWN: view_pos = (view_pos + PAGE > top) ? top : view_pos + PAGE;
                    OP_LINE_UP: if (view_pos > 0) view_pos--;
                    default: view_pos = (view_pos + 1 > top) ? top : view_pos + 1;
                endcase
                move_thumb();
            end
            if (step_q.size() == 0) push_result(1'b0, 0, 0, CH_NUL);
            r = step_q.pop_back();
            r.last = 1'b1;
            step_q.push_back(r);
            foreach (step_q[i]) screen_updates.push_back(step_q[i]);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40) $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report_mismatch($sformatf("result %0d field %s: got %0d, want %0d",
                                          checked, name, got_v, want_v));
        endtask

        task check_update(out_item_t got);
            out_item_t want;
            if (screen_updates.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no item waiting", checked));
                checked++;
                return;
            end
            want = screen_updates.pop_front();
            check_field("write_valid", 32'(got.write_valid), 32'(want.write_valid));
            check_field("write_line", 32'(got.write_line), 32'(want.write_line));
            check_field("write_col", 32'(got.write_col), 32'(want.write_col));
            check_field("write_char", 32'(got.write_char), 32'(want.write_char));
            check_field("cursor_row", 32'(got.cursor_row), 32'(want.cursor_row));
            check_field("cursor_col", 32'(got.cursor_col), 32'(want.cursor_col));
            check_field("view_top", 32'(got.view_top), 32'(want.view_top));
            check_field("line_count", 32'(got.line_count), 32'(want.line_count));
            check_field("thumb_top", 32'(got.thumb_top), 32'(want.thumb_top));
            check_field("thumb_bottom", 32'(got.thumb_bottom), 32'(want.thumb_bottom));
            check_field("last", 32'(got.last), 32'(want.last));
            checked++;
        endtask
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    console_tracker board = new();
    bit quiet = 1'b0;
    bit rx_hold_req = 1'b0;
    int unsigned items_sent = 0;

    text_console_writer_with_scrollback dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t make_item(logic [2:0] op, logic [7:0] ch);
        in_item_t it;
        it.op = op;
        it.ch = ch;
        return it;
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_update(m_item);
            if (s_valid && s_ready) board.take_item(s_item);
        end
    end

    task automatic send_item(in_item_t it);
        int unsigned gap;
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_char(logic [7:0] c);
        send_item(make_item(OP_CHAR, c));
    endtask

    task automatic send_burst();
        int unsigned kind, n;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            n = $urandom_range(1, 8);
            repeat (n) send_char(printable());
            send_char(CH_LF);
        end else if (kind < 48) begin
            n = $urandom_range(COLS - 2, COLS + 6);
            repeat (n) send_char(printable());
            send_char(CH_LF);
        end else if (kind < 58) begin
            n = $urandom_range(1, 12);
            repeat (n) send_char(($urandom_range(0, 1) != 0) ? CH_TAB : printable());
        end else if (kind < 64) begin
            send_char(CH_CR);
            n = $urandom_range(1, 4);
            repeat (n) send_char(printable());
        end else if (kind < 90) begin
            n = $urandom_range(1, 6);
            repeat (n) send_item(make_item(3'($urandom_range(1, 6)), 8'($urandom)));
        end else if (kind < 97) begin
            send_char(8'($urandom));
        end else begin
            send_item(make_item(OP_UNUSED, 8'($urandom)));
        end
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    initial begin : receiver
        int unsigned gap;
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned stalled_cycles;
        stalled_cycles = 0;
        while (stalled_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stalled_cycles = 0;
            else stalled_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned start;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_char(8'd65);
        send_char(8'd255);
        send_char(8'd1);
        send_char(8'd128);
        send_char(CH_TAB);
        send_char(CH_CR);
        send_char(8'h55);
        send_char(8'hAA);
        send_char(CH_LF);
        send_char(CH_LF);
        send_char(CH_NUL);
        send_item(make_item(OP_UNUSED, 8'd65));
        send_item(make_item(OP_START, 8'd0));
        send_item(make_item(OP_END, 8'd255));
        send_item(make_item(OP_PAGE_UP, 8'd0));
        send_item(make_item(OP_PAGE_DOWN, 8'd0));
        send_item(make_item(OP_LINE_UP, 8'd0));
        send_item(make_item(OP_LINE_DOWN, 8'd0));
        send_char(CH_TAB);
        send_char(8'd126);
        send_char(CH_CR);
        send_char(CH_LF);

        start = items_sent;
        while (items_sent - start < 40) send_burst();

        // push the history past one page so the view scrolls
        repeat (30) send_char(CH_LF);

        quiet = 1'b1;
        start = items_sent;
        while (items_sent - start < 10) send_burst();

        rx_hold_req = 1'b1;
        repeat (10) send_item(make_item(3'($urandom_range(0, 6)), printable()));
        quiet = 1'b0;

        pause_until_drained();

        start = items_sent;
        while (items_sent - start < 50) send_burst();

        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
